// File: rtl/ucf_pkg.sv
// Package for the UTF-8 case fold engine: sizes, request and result structs,
// request kinds and controller states. No dependencies.
`timescale 1ns / 1ps
package ucf_pkg;

  // sizes tied to the request field widths
  localparam int TABLE_ENTRIES = 1024;
  localparam int MAP_BYTES     = 8192;
  localparam int MAX_MAP_LEN   = 8;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_MAP   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [9:0]  entry_index;
    logic [30:0] entry_code;
    logic [12:0] map_address;
    logic [3:0]  map_length;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;
    logic       status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_MAPRD,
    ST_MAPOUT,
    ST_COPY
  } state_t;

endpackage

// File: rtl/utf8_case_fold_table_engine.sv
// UTF-8 case fold engine top level: decoder, table search and emit; depends on ucf_pkg.
// Writes and single results finish in the accept cycle; busy stays low.
// A code point takes a SEARCH and a PROBE state per search probe, then a MAPRD and a
// MAPOUT state per mapping byte on a hit, or a COPY state per copied byte, with busy high.
// One request at a time; the receiver cannot stall the results.
// Reset clears decoder and entry_count; tables are undefined until written.
`timescale 1ns / 1ps
module utf8_case_fold_table_engine import ucf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        res_valid,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int MW = $clog2(MAP_BYTES);
  localparam int LW = $clog2(MAX_MAP_LEN + 1);

  logic [30:0] tcode [TABLE_ENTRIES];
  logic [12:0] tstart [TABLE_ENTRIES];
  logic [3:0]  tlen [TABLE_ENTRIES];
  logic [7:0]  mstore [MAP_BYTES];

  state_t state, state_next;
  logic [10:0] entry_count;
  logic [30:0] partial_code;
  logic [2:0]  bytes_remaining;
  logic [7:0]  pending_bytes [6];
  logic [2:0]  pending_count;
  logic [TW:0] lo, hi;
  logic [TW:0] mid;
  logic [TW-1:0] raddr;
  logic [30:0] rd_code;
  logic [12:0] rd_start;
  logic [3:0]  rd_len;
  logic [MW-1:0] maddr;
  logic [7:0]  rd_map;
  logic [LW-1:0] mlen, cnt;
  logic [2:0]  ccnt;
  logic [TW:0] nsat;
  logic        accept;
  logic [7:0]  b;
  logic        is_cont;
  logic        complete;
  logic [30:0] code_now;
  logic [3:0]  clen;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign b         = req.byte_value;
  assign is_cont   = (b[7:6] == 2'b10);
  assign mid       = (lo + hi) >> 1;
  assign nsat      = (entry_count > 11'(TABLE_ENTRIES)) ? (TW+1)'(TABLE_ENTRIES)
                                                        : (TW+1)'(entry_count);
  assign clen      = (rd_len > 4'(MAX_MAP_LEN)) ? 4'(MAX_MAP_LEN) : rd_len;

  // memories
  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_ENTRY && 32'(req.entry_index) < TABLE_ENTRIES) begin
      tcode[req.entry_index[TW-1:0]]  <= req.entry_code;
      tstart[req.entry_index[TW-1:0]] <= req.map_address;
      tlen[req.entry_index[TW-1:0]]   <= req.map_length;
    end
    rd_code  <= tcode[raddr];
    rd_start <= tstart[raddr];
    rd_len   <= tlen[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_MAP && 32'(req.map_address) < MAP_BYTES) begin
      mstore[req.map_address[MW-1:0]] <= b;
    end
    rd_map <= mstore[maddr];
  end

  assign raddr = mid[TW-1:0];

  // decoder step for a text byte
  always_comb begin
    complete = 1'b0;
    code_now = '0;
    if (bytes_remaining != 3'd0) begin
      code_now = {partial_code[24:0], b[5:0]};
      complete = is_cont && bytes_remaining == 3'd1;
    end else begin
      code_now = {23'd0, b};
      complete = !b[7];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.kind == KIND_TEXT && complete && code_now != '0)
          state_next = ST_SEARCH;
      end
      ST_SEARCH: state_next = (lo < hi) ? ST_PROBE : ST_COPY;
      ST_PROBE: begin
        if (rd_code == partial_code) state_next = (clen == 4'd0) ? ST_IDLE : ST_MAPRD;
        else state_next = ST_SEARCH;
      end
      ST_MAPRD:  state_next = ST_MAPOUT;
      ST_MAPOUT: state_next = (cnt + 1'b1 == mlen) ? ST_IDLE : ST_MAPRD;
      ST_COPY:   state_next = (ccnt + 3'd1 >= pending_count) ? ST_IDLE : ST_COPY;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res = '0;
    case (state)
      ST_IDLE: begin
        if (accept && req.kind == KIND_TEXT) begin
          if (bytes_remaining != 3'd0) begin
            if (!is_cont) begin
              res_valid = 1'b1; res.last_of_run = 1'b1; res.status = 1'b1;
            end else if (complete && code_now == '0) begin
              res_valid = 1'b1; res.last_of_run = 1'b1; res.end_of_text = 1'b1;
            end
          end else if (b == 8'd0) begin
            res_valid = 1'b1; res.last_of_run = 1'b1; res.end_of_text = 1'b1;
          end else if ((b[7:6] == 2'b10) || b >= 8'hFE) begin
            res_valid = 1'b1; res.last_of_run = 1'b1; res.status = 1'b1;
          end
        end
      end
      ST_MAPOUT: begin
        res_valid = 1'b1;
        res.out_byte = rd_map;
        res.last_of_run = (cnt + 1'b1 == mlen);
      end
      ST_COPY: begin
        res_valid = 1'b1;
        res.out_byte = pending_bytes[ccnt];
        res.last_of_run = (ccnt + 3'd1 >= pending_count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry_count <= '0;
      partial_code <= '0;
      bytes_remaining <= '0;
      pending_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entry_count <= cfg_data;
      if (state == ST_IDLE && accept && req.kind == KIND_TEXT) begin
        if (bytes_remaining != 3'd0) begin
          if (!is_cont) begin
            bytes_remaining <= '0; partial_code <= '0; pending_count <= '0;
          end else begin
            partial_code <= code_now;
            bytes_remaining <= bytes_remaining - 3'd1;
            if (pending_count < 3'd6) begin
              pending_bytes[pending_count] <= b;
              pending_count <= pending_count + 3'd1;
            end
          end
        end else begin
          pending_bytes[0] <= b;
          pending_count <= 3'd1;
          bytes_remaining <= '0;
          partial_code <= code_now;
          if (b >= 8'hC0 && b < 8'hE0) begin
            partial_code <= {26'd0, b[4:0]}; bytes_remaining <= 3'd1;
          end else if (b >= 8'hE0 && b < 8'hF0) begin
            partial_code <= {27'd0, b[3:0]}; bytes_remaining <= 3'd2;
          end else if (b >= 8'hF0 && b < 8'hF8) begin
            partial_code <= {28'd0, b[2:0]}; bytes_remaining <= 3'd3;
          end else if (b >= 8'hF8 && b < 8'hFC) begin
            partial_code <= {29'd0, b[1:0]}; bytes_remaining <= 3'd4;
          end else if (b == 8'hFC || b == 8'hFD) begin
            partial_code <= {30'd0, b[0]}; bytes_remaining <= 3'd5;
          end else if (b == 8'd0 || b[7]) begin
            partial_code <= '0; pending_count <= '0;
          end
        end
        lo <= '0;
        hi <= nsat;
        ccnt <= '0;
      end
      if (state == ST_PROBE) begin
        if (rd_code < partial_code) lo <= mid + 1'b1;
        else hi <= mid;
        maddr <= MW'(rd_start);
        mlen <= LW'(clen);
        cnt <= '0;
      end
      if (state == ST_MAPOUT) begin
        cnt <= cnt + 1'b1;
        maddr <= maddr + 1'b1;
      end
      if (state == ST_COPY) ccnt <= ccnt + 3'd1;
      if (state_next == ST_IDLE && state != ST_IDLE) begin
        partial_code <= '0; bytes_remaining <= '0; pending_count <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_res_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_PROBE || state == ST_MAPRD) |-> !res_valid)
    else $error("result during search");
  a_lo_le_hi: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && $past(state) == ST_IDLE) |-> (bytes_remaining == 3'd0))
    else $error("search started mid sequence");
`endif

endmodule

// File: bench/utf8_case_fold_table_engine_tb.sv
// Testbench for utf8_case_fold_table_engine: random and directed UTF-8 text, table and
// mapping loads, each result checked against an in-bench fold predictor.
// Depends on ucf_pkg and the engine RTL.
`timescale 1ns / 1ps
module utf8_case_fold_table_engine_tb;
  import ucf_pkg::*;

  localparam int NUM_ENTRIES = 1024;
  localparam int NUM_MAP     = 8192;
  localparam int MAP_LEN_MAX = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 60;
  localparam int TBL_USED    = 16;
  localparam int MAP_SPAN    = 40;

  class fold_scoreboard;
    logic [30:0] fold_code [NUM_ENTRIES];
    logic [12:0] fold_start[NUM_ENTRIES];
    logic [3:0]  fold_len  [NUM_ENTRIES];
    logic [7:0]  map_mem   [NUM_MAP];
    logic [10:0] entry_count;
    logic [30:0] partial;
    int          remaining;
    logic [7:0]  pend[6];
    int          pend_cnt;
    res_t        expected_q[$];
    int          errors;

    function new();
      entry_count = '0;
      errors = 0;
      clear_decoder();
    endfunction

    function void clear_decoder();
      partial = '0;
      remaining = 0;
      pend_cnt = 0;
      foreach (pend[i]) pend[i] = '0;
    endfunction

    function void push(logic [7:0] b, logic last, logic eot, logic err);
      res_t r;
      r.out_byte = b;
      r.last_of_run = last;
      r.end_of_text = eot;
      r.status = err;
      expected_q.push_back(r);
    endfunction

    function void finish_code();
      int n, lo, hi, mid, hit, len;
      logic [12:0] a;
      hit = -1;
      if (partial == '0) begin
        clear_decoder();
        push(8'd0, 1'b1, 1'b1, 1'b0);
        return;
      end
      n = (entry_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(entry_count);
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (fold_code[mid] == partial) begin
          hit = mid;
          break;
        end
        if (fold_code[mid] < partial) lo = mid + 1;
        else hi = mid;
      end
      if (hit >= 0) begin
        len = (fold_len[hit] > MAP_LEN_MAX) ? MAP_LEN_MAX : int'(fold_len[hit]);
        for (int i = 0; i < len; i++) begin
          a = fold_start[hit] + i[12:0];
          push(map_mem[a], i + 1 == len, 1'b0, 1'b0);
        end
      end else begin
        for (int i = 0; i < pend_cnt; i++) push(pend[i], i + 1 == pend_cnt, 1'b0, 1'b0);
      end
      clear_decoder();
    endfunction

    function void text_byte(logic [7:0] b);
      if (remaining != 0) begin
        if (b[7:6] != 2'b10) begin
          clear_decoder();
          push(8'd0, 1'b1, 1'b0, 1'b1);
          return;
        end
        partial = {partial[24:0], b[5:0]};
        if (pend_cnt < 6) begin
          pend[pend_cnt] = b;
          pend_cnt++;
        end
        remaining--;
        if (remaining == 0) finish_code();
        return;
      end
      clear_decoder();
      if (b == 8'd0) begin
        push(8'd0, 1'b1, 1'b1, 1'b0);
        return;
      end
      if (b < 8'h80) begin
        partial = {23'd0, b};
      end else if (b < 8'hC0 || b >= 8'hFE) begin
        push(8'd0, 1'b1, 1'b0, 1'b1);
        return;
      end else if (b < 8'hE0) begin
        partial = {26'd0, b[4:0]}; remaining = 1;
      end else if (b < 8'hF0) begin
        partial = {27'd0, b[3:0]}; remaining = 2;
      end else if (b < 8'hF8) begin
        partial = {28'd0, b[2:0]}; remaining = 3;
      end else if (b < 8'hFC) begin
        partial = {29'd0, b[1:0]}; remaining = 4;
      end else begin
        partial = {30'd0, b[0]}; remaining = 5;
      end
      pend[0] = b;
      pend_cnt = 1;
      if (remaining == 0) finish_code();
    endfunction

    function void note_request(req_t r);
      case (kind_t'(r.kind))
        KIND_TEXT: text_byte(r.byte_value);
        KIND_ENTRY: begin
          fold_code[r.entry_index] = r.entry_code;
          fold_start[r.entry_index] = r.map_address;
          fold_len[r.entry_index] = r.map_length;
        end
        KIND_MAP: map_mem[r.map_address] = r.byte_value;
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
          got.end_of_text !== want.end_of_text || got.status !== want.status) begin
        $display("%0t: result mismatch, expected byte %h last %b eot %b status %b,",
                 $time, want.out_byte, want.last_of_run, want.end_of_text, want.status);
        $display("%0t:   actual byte %h last %b eot %b status %b",
                 $time, got.out_byte, got.last_of_run, got.end_of_text, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        res_valid;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  fold_scoreboard sb;
  int idle_pct;
  int stall_cycles;

  utf8_case_fold_table_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // requests are noted before results so a same-cycle result finds its entry
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(req);
    if (!rst && res_valid) sb.check_result(res);
    if (rst || res_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("[utf8_case_fold_table_engine] ERROR");
        $finish;
      end
    end
  end

  function req_t noise_req();
    logic [95:0] w;
    w = {$urandom(), $urandom(), $urandom()};
    return req_t'(w[67:0]);
  endfunction

  task automatic send_req(input req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_text(input logic [7:0] b);
    req_t r;
    r = noise_req();
    r.kind = KIND_TEXT;
    r.byte_value = b;
    send_req(r);
  endtask

  task automatic send_entry(input int idx, input logic [30:0] code, input logic [12:0] addr,
                            input logic [3:0] len);
    req_t r;
    r = noise_req();
    r.kind = KIND_ENTRY;
    r.entry_index = 10'(idx);
    r.entry_code = code;
    r.map_address = addr;
    r.map_length = len;
    send_req(r);
  endtask

  task automatic send_map(input logic [12:0] addr, input logic [7:0] b);
    req_t r;
    r = noise_req();
    r.kind = KIND_MAP;
    r.map_address = addr;
    r.byte_value = b;
    send_req(r);
  endtask

  // n-byte form of a code point, overlong when n exceeds the minimum
  task automatic send_code(input logic [31:0] c, input int n);
    logic [7:0] lead;
    if (n == 1) lead = c[7:0];
    else lead = 8'((8'hFF << (8 - n)) | ((c >> (6 * (n - 1))) & (8'h7F >> n)));
    send_text(lead);
    for (int k = n - 2; k >= 0; k--) send_text(8'(8'h80 | ((c >> (6 * k)) & 8'h3F)));
  endtask

  function int min_len(input logic [31:0] c);
    if (c < 32'h80) return 1;
    if (c < 32'h800) return 2;
    if (c < 32'h10000) return 3;
    if (c < 32'h200000) return 4;
    if (c < 32'h4000000) return 5;
    return 6;
  endfunction

  function logic [30:0] sorted_code(input int i);
    return (i == TBL_USED - 1) ? 31'h7FFFFFFF : 31'(32'h41 + 2 * i);
  endfunction

  function logic [12:0] map_start();
    return 13'($urandom_range(0, MAP_SPAN - MAP_LEN_MAX));
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [10:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.entry_count = v;
  endtask

  task automatic random_step();
    int sel, n, cut;
    logic [31:0] c;
    req_t r;
    sel = $urandom_range(99);
    if (sel < 45) begin
      c = (sel < 20) ? 32'h41 + 2 * $urandom_range(0, TBL_USED + 3) : $urandom_range(1, 32'h900);
      n = min_len(c);
      if ($urandom_range(9) == 0) n = $urandom_range(n, 6);
      send_code(c, n);
    end else if (sel < 60) begin
      n = $urandom_range(2, 6);
      c = $urandom() & ((32'd1 << (5 * n + 1)) - 1);
      if ($urandom_range(5) == 0) begin
        n = 6;
        c = 32'h7FFFFFFF;
      end
      send_code(c, n);
    end else if (sel < 65) begin
      send_text(8'h00);
    end else if (sel < 75) begin
      send_text(8'($urandom_range(1, 127)));
    end else if (sel < 85) begin
      n = $urandom_range(2, 6);
      cut = $urandom_range(0, n - 2);
      send_text(8'((8'hFF << (8 - n)) | ($urandom() & (8'h7F >> n))));
      repeat (cut) send_text(8'(8'h80 | $urandom_range(0, 63)));
      c = $urandom_range(0, 255);
      if (c[7:6] == 2'b10) c[6] = 1'b1;
      send_text(c[7:0]);
    end else if (sel < 92) begin
      send_text(8'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      n = $urandom_range(0, TBL_USED - 1);
      send_entry(n, sorted_code(n), map_start(), 4'($urandom()));
    end else if (sel < 97) begin
      send_entry($urandom_range(0, 2 * TBL_USED - 1), 31'($urandom()), map_start(),
                 4'($urandom()));
    end else if (sel < 99) begin
      send_map(13'($urandom()), 8'($urandom()));
    end else begin
      r = noise_req();
      r.kind = KIND_NONE;
      send_req(r);
    end
  endtask

  initial begin
    logic [10:0] cfg_list[6];
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    stall_cycles = 0;
    cfg_list = '{11'd16, 11'd1, 11'd0, 11'd9, 11'd16, 11'd5};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every nonzero code point copies through
    send_text(8'h00);
    send_text(8'h41);
    send_text(8'h7F);
    send_text(8'h80);
    send_text(8'hBF);
    send_text(8'hFE);
    send_text(8'hFF);
    send_code(32'hE9, 2);
    send_text(8'hC3);
    send_text(8'h41);
    send_text(8'hE2);
    send_text(8'h82);
    send_text(8'h00);
    send_code(32'h20AC, 3);
    send_code(32'h1F600, 4);
    send_code(32'h200000, 5);
    send_code(32'h4000000, 6);
    send_code(32'h0, 2);
    begin
      req_t r;
      r = noise_req();
      r.kind = KIND_NONE;
      send_req(r);
    end

    for (int a = 0; a < MAP_SPAN; a++) send_map(13'(a), 8'($urandom()));
    for (int a = 0; a < 8; a++) send_map(13'(32'h1FF8 + a), 8'($urandom()));
    for (int i = 0; i < TBL_USED; i++) begin
      if (i == 1) send_entry(i, sorted_code(i), 13'h1FFC, 4'hF);
      else if (i == 2) send_entry(i, sorted_code(i), map_start(), 4'h0);
      else send_entry(i, sorted_code(i), map_start(), 4'($urandom()));
    end

    write_cfg(11'd16);
    send_code(32'h43, 1);
    send_code(32'h45, 1);
    send_code(32'h7FFFFFFF, 6);
    send_code(32'h43, 2);
    send_code(32'h47, 1);
    send_code(32'h42, 1);

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(cfg_list[ph]);
      idle_pct = (ph < 2) ? 26 : (ph < 4) ? 58 : 0;
      for (int k = 0; k < 12; k++) begin
        random_step();
        if (k == 6 && ph == 1) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[utf8_case_fold_table_engine] OK");
    end else begin
      $display("[utf8_case_fold_table_engine] ERROR");
    end
    $finish;
  end
endmodule

// File: utf8_case_fold_table_engine.f
rtl/ucf_pkg.sv
rtl/utf8_case_fold_table_engine.sv
bench/utf8_case_fold_table_engine_tb.sv
